// ===== design/gdw_pkg.sv =====
// shared types and constants for the depth-first graph walker
package gdw_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;
  localparam int TYPE_W = 2;
  localparam int VTX_W  = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_START = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_B   = 2'd1;
  localparam logic [1:0] SEL_TOP = 2'd2;
  localparam logic [1:0] SEL_STK = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       clear_rows;
    logic       walk_init;
    logic       row_wr_a;
    logic       row_wr_b;
    logic       push;
    logic       pop;
    logic       load_top;
    logic [1:0] row_sel;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic start_ok;
    logic push_ok;
    logic depth_one;
  } stat_t;

endpackage

// ===== design/gdw_cfg.sv =====
// configuration register port and active vertex count
module gdw_cfg #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gdw_pkg::ADDR_W-1:0]  paddr,
  input  logic [gdw_pkg::DATA_W-1:0]  pwdata,
  output logic [gdw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [$clog2(MAX_VERTICES+1)-1:0] n
);

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (NW > gdw_pkg::CFG_W) ? NW : gdw_pkg::CFG_W;

  logic [gdw_pkg::CFG_W-1:0] vertex_count;
  logic [XW-1:0]             vc_x;
  logic [XW-1:0]             n_x;
  logic                      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == gdw_pkg::REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gdw_pkg::CFG_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      vertex_count <= pwdata[gdw_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_hit ? gdw_pkg::DATA_W'(vertex_count) : '0;

  always_comb begin
    vc_x = XW'(vertex_count);
    if (vc_x == '0) begin
      n_x = XW'(1);
    end else if (vc_x > XW'(MAX_VERTICES)) begin
      n_x = XW'(MAX_VERTICES);
    end else begin
      n_x = vc_x;
    end
  end

  assign n = n_x[NW-1:0];

endmodule

// ===== design/gdw_ctrl.sv =====
// sequencing state machine for edge updates and the walk
module gdw_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gdw_pkg::TYPE_W-1:0]  req_type,
  input  gdw_pkg::stat_t              stat,
  output gdw_pkg::cmd_t               cmd,
  output logic                        busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RA = 3'd1;
  localparam logic [2:0] S_ADD_WA = 3'd2;
  localparam logic [2:0] S_ADD_RB = 3'd3;
  localparam logic [2:0] S_ADD_WB = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_SCAN   = 3'd6;
  localparam logic [2:0] S_LOAD   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.row_sel = gdw_pkg::SEL_TOP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            gdw_pkg::REQ_ADD: begin
              if (stat.add_ok) begin
                cmd.capture = 1'b1;
                state_next  = S_ADD_RA;
              end
            end
            gdw_pkg::REQ_START: begin
              cmd.walk_init = 1'b1;
              if (stat.start_ok) begin
                state_next = S_FETCH;
              end
            end
            gdw_pkg::REQ_CLEAR: begin
              cmd.clear_rows = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_RA: begin
        cmd.row_sel = gdw_pkg::SEL_A;
        state_next  = S_ADD_WA;
      end
      S_ADD_WA: begin
        cmd.row_wr_a = 1'b1;
        state_next   = S_ADD_RB;
      end
      S_ADD_RB: begin
        cmd.row_sel = gdw_pkg::SEL_B;
        state_next  = S_ADD_WB;
      end
      S_ADD_WB: begin
        cmd.row_wr_b = 1'b1;
        state_next   = S_IDLE;
      end
      S_FETCH: begin
        cmd.row_sel = gdw_pkg::SEL_TOP;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        if (stat.push_ok) begin
          cmd.push   = 1'b1;
          state_next = S_FETCH;
        end else begin
          cmd.pop    = 1'b1;
          state_next = stat.depth_one ? S_IDLE : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.row_sel  = gdw_pkg::SEL_STK;
        cmd.load_top = 1'b1;
        state_next   = S_SCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/gdw_dp.sv =====
// adjacency memory, vertex stack, visited marks and result register
module gdw_dp #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gdw_pkg::cmd_t                     cmd,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] n,
  input  logic [gdw_pkg::VTX_W-1:0]         vertex_a,
  input  logic [gdw_pkg::VTX_W-1:0]         vertex_b,
  output gdw_pkg::stat_t                    stat,
  output logic                              result_valid,
  output logic [gdw_pkg::VTX_W-1:0]         visited_vertex,
  output logic                              last
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int XW  = (NW > gdw_pkg::CFG_W) ? NW : gdw_pkg::CFG_W;

  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] row_rdata;
  logic                    row_rvalid;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [VIW-1:0]          row_raddr;
  logic                    row_we;
  logic [VIW-1:0]          row_waddr;
  logic [MAX_VERTICES-1:0] row_wdata;

  logic [VIW-1:0]          stk_mem [MAX_VERTICES];
  logic [VIW-1:0]          stk_rdata;
  logic                    stk_we;
  logic [VIW-1:0]          stk_waddr;
  logic [VIW-1:0]          stk_wdata;
  logic [NW-1:0]           depth_m2;

  logic [VIW-1:0]          ea;
  logic [VIW-1:0]          eb;
  logic [VIW-1:0]          top;
  logic [VIW-1:0]          pend;
  logic [NW-1:0]           depth;
  logic [MAX_VERTICES-1:0] visited;

  logic [XW-1:0]           a_x;
  logic [XW-1:0]           b_x;
  logic [XW-1:0]           pend_x;
  logic [VIW-1:0]          a_v;
  logic [VIW-1:0]          b_v;
  logic                    a_ok;
  logic                    b_ok;
  logic [MAX_VERTICES-1:0] nmask;
  logic [MAX_VERTICES-1:0] cand;
  logic [VIW-1:0]          enc;
  logic                    found;

  assign a_x    = XW'(vertex_a);
  assign b_x    = XW'(vertex_b);
  assign a_v    = a_x[VIW-1:0];
  assign b_v    = b_x[VIW-1:0];
  assign a_ok   = a_x < XW'(n);
  assign b_ok   = b_x < XW'(n);
  assign pend_x = XW'(pend);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = XW'(i) < XW'(n);
    end
  end

  // adjacency rows: one write, one registered read, valid bit per row
  always_comb begin
    case (cmd.row_sel)
      gdw_pkg::SEL_A:   row_raddr = ea;
      gdw_pkg::SEL_B:   row_raddr = eb;
      gdw_pkg::SEL_TOP: row_raddr = top;
      gdw_pkg::SEL_STK: row_raddr = stk_rdata;
      default:          row_raddr = top;
    endcase
  end

  assign row_eff   = row_rvalid ? row_rdata : '0;
  assign row_we    = cmd.row_wr_a | cmd.row_wr_b;
  assign row_waddr = cmd.row_wr_a ? ea : eb;
  assign row_wdata = row_eff | (MAX_VERTICES'(1) << (cmd.row_wr_a ? eb : ea));

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rdata <= row_mem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_rows) begin
      row_valid  <= '0;
      row_rvalid <= 1'b0;
    end else begin
      if (row_we) begin
        row_valid[row_waddr] <= 1'b1;
      end
      row_rvalid <= row_valid[row_raddr];
    end
  end

  // lowest unvisited neighbor of the top vertex
  assign cand  = row_eff & ~visited & nmask;
  assign found = |cand;

  always_comb begin
    enc = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        enc = VIW'(i);
      end
    end
  end

  assign stat.add_ok    = a_ok & b_ok;
  assign stat.start_ok  = a_ok;
  assign stat.push_ok   = found && (depth < NW'(MAX_VERTICES));
  assign stat.depth_one = (depth == NW'(1));

  // vertex stack
  assign stk_we    = (cmd.walk_init & a_ok) | cmd.push;
  assign stk_waddr = cmd.walk_init ? '0 : depth[VIW-1:0];
  assign stk_wdata = cmd.walk_init ? a_v : enc;
  assign depth_m2  = depth - NW'(2);

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[depth_m2[VIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth        <= '0;
      visited      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.walk_init) begin
        depth   <= a_ok ? NW'(1) : '0;
        visited <= a_ok ? (MAX_VERTICES'(1) << a_v) : '0;
      end
      if (cmd.push) begin
        depth        <= depth + NW'(1);
        visited      <= visited | (MAX_VERTICES'(1) << enc);
        result_valid <= 1'b1;
      end
      if (cmd.pop) begin
        depth <= depth - NW'(1);
        if (depth == NW'(1)) begin
          result_valid <= 1'b1;
        end
      end
    end
  end

  // the newest vertex waits in pend until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ea <= a_v;
      eb <= b_v;
    end
    if (cmd.walk_init) begin
      top  <= a_v;
      pend <= a_v;
    end
    if (cmd.push) begin
      top            <= enc;
      pend           <= enc;
      visited_vertex <= pend_x[gdw_pkg::VTX_W-1:0];
      last           <= 1'b0;
    end
    if (cmd.pop && (depth == NW'(1))) begin
      visited_vertex <= pend_x[gdw_pkg::VTX_W-1:0];
      last           <= 1'b1;
    end
    if (cmd.load_top) begin
      top <= stk_rdata;
    end
  end

endmodule

// ===== design/graph_dfs_walker.sv =====
// Depth-first walker over an undirected adjacency bit matrix. A request is taken
// when start is high and busy is low. Add-edge keeps busy high while it reads and
// writes the row of vertex a, then that of vertex b; clear takes effect at once and
// never raises busy. A walk alternates a registered read of an adjacency row (the
// stack's new top after a pop) and a priority-encoder scan that pushes or pops. Each
// vertex appears on visited_vertex for one cycle with result_valid high, in push
// order, one vertex behind the walk; the final one carries last and appears in the
// same cycle that busy falls. Results cannot be held off, so the receiver must take
// every beat. The vertex_count register sits at byte address 0; the user must see
// that it is written only while idle, which the block itself does not enforce.
module graph_dfs_walker #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gdw_pkg::ADDR_W-1:0]  paddr,
  input  logic [gdw_pkg::DATA_W-1:0]  pwdata,
  output logic [gdw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  input  logic [gdw_pkg::TYPE_W-1:0]  req_type,
  input  logic [gdw_pkg::VTX_W-1:0]   vertex_a,
  input  logic [gdw_pkg::VTX_W-1:0]   vertex_b,
  output logic                        busy,
  output logic                        result_valid,
  output logic [gdw_pkg::VTX_W-1:0]   visited_vertex,
  output logic                        last
);

  localparam int NW = $clog2(MAX_VERTICES + 1);

  logic [NW-1:0]  n;
  gdw_pkg::cmd_t  cmd;
  gdw_pkg::stat_t stat;

  gdw_cfg #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n       (n)
  );

  gdw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  gdw_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .n              (n),
    .vertex_a       (vertex_a),
    .vertex_b       (vertex_b),
    .stat           (stat),
    .result_valid   (result_valid),
    .visited_vertex (visited_vertex),
    .last           (last)
  );

endmodule

// ===== tb/tb_graph_dfs_walker.sv =====
// self-checking testbench for graph_dfs_walker with an in-bench depth-first walk predictor
module tb_graph_dfs_walker;

  localparam int NV = 16;
  localparam int RANDOM_ITEMS = 385;
  localparam logic [gdw_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [gdw_pkg::ADDR_W-1:0] VCOUNT_ADDR = {gdw_pkg::REG_VERTEX_COUNT, 2'b00};

  typedef logic [gdw_pkg::VTX_W-1:0] vtx_t;
  typedef logic [gdw_pkg::CFG_W-1:0] cfgv_t;

  typedef struct packed {
    logic [gdw_pkg::VTX_W-1:0] vtx;
    logic                      fin;
  } visit_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [gdw_pkg::ADDR_W-1:0]  paddr = '0;
  logic [gdw_pkg::DATA_W-1:0]  pwdata = '0;
  logic [gdw_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        start = 1'b0;
  logic [gdw_pkg::TYPE_W-1:0]  req_type = '0;
  logic [gdw_pkg::VTX_W-1:0]   vertex_a = '0;
  logic [gdw_pkg::VTX_W-1:0]   vertex_b = '0;
  logic                        busy;
  logic                        result_valid;
  logic [gdw_pkg::VTX_W-1:0]   visited_vertex;
  logic                        last;

  logic [NV-1:0]               adj_rows [NV];
  logic [gdw_pkg::CFG_W-1:0]   vcount_reg = gdw_pkg::CFG_RESET;
  visit_t                      pending_visits [$];
  int                          errors = 0;
  int                          items_sent = 0;
  int                          walks_sent = 0;
  int                          ignored_sent = 0;
  int                          visits_checked = 0;
  int                          count_writes = 0;
  bit                          steady = 1'b0;

  graph_dfs_walker #(.MAX_VERTICES(NV)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .req_type(req_type), .vertex_a(vertex_a), .vertex_b(vertex_b),
    .busy(busy), .result_valid(result_valid), .visited_vertex(visited_vertex),
    .last(last)
  );

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int active_vertices();
    int n;
    n = vcount_reg;
    if (n < 1) n = 1;
    if (n > NV) n = NV;
    return n;
  endfunction

  task automatic expect_walk(input logic [gdw_pkg::VTX_W-1:0] root);
    logic [NV-1:0]             seen;
    logic [NV-1:0]             row;
    logic [gdw_pkg::VTX_W-1:0] stk [NV];
    logic [gdw_pkg::VTX_W-1:0] order [NV];
    int                        depth;
    int                        cnt;
    int                        n;
    int                        pick;
    int                        i;
    visit_t                    v;
    n = active_vertices();
    seen = '0;
    if (root >= n) return;
    stk[0] = root;
    depth = 1;
    seen[root] = 1'b1;
    order[0] = root;
    cnt = 1;
    while (depth > 0) begin
      row = adj_rows[stk[depth-1]] & ~seen;
      pick = -1;
      for (i = 0; i < n; i++) begin
        if (row[i] && pick < 0) pick = i;
      end
      if (pick >= 0 && depth < NV) begin
        stk[depth] = vtx_t'(pick);
        depth++;
        seen[pick] = 1'b1;
        order[cnt] = vtx_t'(pick);
        cnt++;
      end else begin
        depth--;
      end
    end
    for (i = 0; i < cnt; i++) begin
      v.vtx = order[i];
      v.fin = (i == cnt - 1);
      pending_visits.push_back(v);
    end
  endtask

  task automatic update_model(input logic [gdw_pkg::TYPE_W-1:0] kind,
                              input logic [gdw_pkg::VTX_W-1:0] a,
                              input logic [gdw_pkg::VTX_W-1:0] b, output bit effective);
    int n;
    n = active_vertices();
    effective = 1'b0;
    case (kind)
      gdw_pkg::REQ_ADD: begin
        if (a < n && b < n) begin
          adj_rows[a][b] = 1'b1;
          adj_rows[b][a] = 1'b1;
          effective = 1'b1;
        end
      end
      gdw_pkg::REQ_CLEAR: begin
        foreach (adj_rows[k]) adj_rows[k] = '0;
        effective = 1'b1;
      end
      gdw_pkg::REQ_START: begin
        walks_sent++;
        expect_walk(a);
        effective = (a < n);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_req(input logic [gdw_pkg::TYPE_W-1:0] kind,
                           input logic [gdw_pkg::VTX_W-1:0] a,
                           input logic [gdw_pkg::VTX_W-1:0] b);
    int gap;
    bit effective;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req_type <= kind;
    vertex_a <= a;
    vertex_b <= b;
    do @(posedge clk); while (busy);
    update_model(kind, a, b, effective);
    if (effective) items_sent++;
    else ignored_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [gdw_pkg::CFG_W-1:0] value);
    logic [gdw_pkg::DATA_W-1:0] word;
    word = $urandom();
    word[gdw_pkg::CFG_W-1:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= VCOUNT_ADDR;
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    vcount_reg = value;
    count_writes++;
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== gdw_pkg::DATA_W'(value)) begin
      errors++;
      $display("%0t: vertex_count readback expected %0d actual %0d", $time, value, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    visit_t want;
    if (!rst && result_valid) begin
      if (pending_visits.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual vertex %0d last %0b",
                 $time, visited_vertex, last);
      end else begin
        want = pending_visits.pop_front();
        visits_checked++;
        if (visited_vertex !== want.vtx) begin
          errors++;
          $display("%0t: visited_vertex expected %0d actual %0d", $time, want.vtx,
                   visited_vertex);
        end
        if (last !== want.fin) begin
          errors++;
          $display("%0t: last expected %0b actual %0b (vertex %0d)", $time, want.fin, last,
                   want.vtx);
        end
      end
    end
  end

  task automatic test_empty_graph();
    issue_req(gdw_pkg::REQ_START, 4'd0, 4'd0);
    issue_req(gdw_pkg::REQ_START, 4'd15, 4'd15);
    issue_req(REQ_UNUSED, 4'd15, 4'd15);
  endtask

  task automatic test_small_graph();
    issue_req(gdw_pkg::REQ_ADD, 4'd0, 4'd1);
    issue_req(gdw_pkg::REQ_ADD, 4'd1, 4'd2);
    issue_req(gdw_pkg::REQ_ADD, 4'd0, 4'd15);
    issue_req(gdw_pkg::REQ_ADD, 4'd15, 4'd14);
    issue_req(gdw_pkg::REQ_ADD, 4'd3, 4'd3);
    issue_req(gdw_pkg::REQ_ADD, 4'd2, 4'd0);
    issue_req(gdw_pkg::REQ_START, 4'd0, 4'd7);
    issue_req(gdw_pkg::REQ_START, 4'd3, 4'd0);
    issue_req(gdw_pkg::REQ_START, 4'd15, 4'd0);
  endtask

  task automatic test_reduced_count();
    issue_req(gdw_pkg::REQ_ADD, 4'd4, 4'd10);
    wait_quiet();
    cfg_write(5'd8);
    issue_req(gdw_pkg::REQ_START, 4'd4, 4'd0);
    issue_req(gdw_pkg::REQ_ADD, 4'd4, 4'd9);
    issue_req(gdw_pkg::REQ_START, 4'd12, 4'd0);
    wait_quiet();
    cfg_write(5'd16);
    issue_req(gdw_pkg::REQ_START, 4'd4, 4'd0);
    issue_req(gdw_pkg::REQ_CLEAR, 4'd0, 4'd0);
    issue_req(gdw_pkg::REQ_START, 4'd0, 4'd0);
  endtask

  task automatic test_count_extremes();
    wait_quiet();
    cfg_write(5'd0);
    issue_req(gdw_pkg::REQ_ADD, 4'd0, 4'd0);
    issue_req(gdw_pkg::REQ_START, 4'd0, 4'd0);
    issue_req(gdw_pkg::REQ_START, 4'd1, 4'd0);
    wait_quiet();
    cfg_write(5'd31);
    issue_req(gdw_pkg::REQ_START, 4'd15, 4'd0);
  endtask

  task automatic test_random();
    int base;
    int n;
    int nedges;
    int nwalks;
    int r;
    logic [gdw_pkg::CFG_W-1:0] value;
    base = items_sent + ignored_sent;
    while ((items_sent + ignored_sent) - base < RANDOM_ITEMS) begin
      wait_quiet();
      r = $urandom_range(0, 99);
      if (r < 8) value = 5'd0;
      else if (r < 16) value = cfgv_t'($urandom_range(17, 31));
      else if (r < 40) value = 5'd16;
      else if (r < 48) value = 5'd1;
      else value = cfgv_t'($urandom_range(2, 15));
      cfg_write(value);
      steady = ($urandom_range(0, 4) == 0);
      n = active_vertices();
      if ($urandom_range(0, 2) != 0) begin
        issue_req(gdw_pkg::REQ_CLEAR, vtx_t'($urandom()), vtx_t'($urandom()));
      end
      nedges = $urandom_range(0, 2 * n);
      repeat (nedges) begin
        r = $urandom_range(0, 19);
        if (r == 0) issue_req(REQ_UNUSED, vtx_t'($urandom()), vtx_t'($urandom()));
        else if (r == 1) issue_req(gdw_pkg::REQ_ADD, vtx_t'($urandom()), vtx_t'($urandom()));
        else issue_req(gdw_pkg::REQ_ADD, vtx_t'($urandom_range(0, n - 1)),
                       vtx_t'($urandom_range(0, n - 1)));
      end
      nwalks = $urandom_range(1, 4);
      repeat (nwalks) begin
        if ($urandom_range(0, 9) == 0) begin
          issue_req(gdw_pkg::REQ_START, vtx_t'($urandom()), vtx_t'($urandom()));
        end else begin
          issue_req(gdw_pkg::REQ_START, vtx_t'($urandom_range(0, n - 1)),
                    vtx_t'($urandom()));
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (adj_rows[k]) adj_rows[k] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_graph();
    test_small_graph();
    test_reduced_count();
    test_count_extremes();
    test_random();
    wait_quiet();
    repeat (20) @(posedge clk);
    if (pending_visits.size() != 0) begin
      errors += pending_visits.size();
      $display("%0t: %0d expected beats never arrived, expected 0 actual %0d", $time,
               pending_visits.size(), pending_visits.size());
    end
    $display("covered %0d requests (%0d walks, %0d ignored) over %0d vertex_count settings",
             items_sent + ignored_sent, walks_sent, ignored_sent, count_writes);
    $display("checked %0d visited-vertex beats, %0d errors", visits_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
